@@ src/sfr_pkg.sv @@
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants of the sonar frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

    // Parse phases; every 3-bit code has a meaning
    typedef enum logic [2:0] {
        PH_WAIT   = 3'd0,
        PH_START1 = 3'd1,
        PH_LENGTH = 3'd2,
        PH_MSGID  = 3'd3,
        PH_SRC    = 3'd4,
        PH_DST    = 3'd5,
        PH_DATA   = 3'd6,
        PH_CHECK  = 3'd7
    } t_phase;

    typedef enum logic [1:0] {
        ST_INCOMPLETE = 2'd0,
        ST_COMPLETE   = 2'd1,
        ST_ERROR      = 2'd2
    } t_status;

    // Configuration register indexes
    localparam logic [1:0] CFG_START_FIRST  = 2'd0;
    localparam logic [1:0] CFG_START_SECOND = 2'd1;
    localparam logic [1:0] CFG_SOURCE_ID    = 2'd2;
    localparam logic [1:0] CFG_DEST_ID      = 2'd3;

    localparam logic [7:0] START_FIRST_RST  = 8'd66;
    localparam logic [7:0] START_SECOND_RST = 8'd82;

    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 3;

    typedef struct packed {
        logic [7:0] start_byte_first;
        logic [7:0] start_byte_second;
        logic [7:0] source_device_id;
        logic [7:0] dest_device_id;
    } t_cfg;

    typedef struct packed {
        t_status     parse_status;
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic [15:0] frame_msg_id;
        logic [8:0]  frame_length;
    } t_result;

endpackage

@@ src/sfr_parser.sv @@
// ----------------------------------------------------------------------------
// sfr_parser
// Frame state and one-byte-per-cycle parse step, taken while i_step is high, with the result it yields.
// ----------------------------------------------------------------------------
module sfr_parser
    import sfr_pkg::*;
#(
    parameter int MAX_PAYLOAD = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_rx_byte,
    input  t_cfg       i_cfg,
    output t_result    o_result
);

    t_phase      r_phase,   n_phase;
    logic [8:0]  r_cnt,     n_cnt;
    logic [15:0] r_len,     n_len;
    logic [15:0] r_msg,     n_msg;
    logic [15:0] r_sum,     n_sum;
    logic [7:0]  r_ck_low,  n_ck_low;

    logic        err;
    logic        pvalid;
    logic [8:0]  cnt_inc;
    logic [15:0] sum_add;
    logic [15:0] len_full;

    assign cnt_inc  = r_cnt + 9'd1;
    assign sum_add  = r_sum + {8'd0, i_rx_byte};
    assign len_full = {i_rx_byte, r_len[7:0]};

    always_comb begin
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_len    = r_len;
        n_msg    = r_msg;
        n_sum    = r_sum;
        n_ck_low = r_ck_low;
        err      = 1'b0;
        pvalid   = 1'b0;
        o_result.parse_status = ST_INCOMPLETE;

        unique case (r_phase)
            PH_START1: begin
                if (i_rx_byte == i_cfg.start_byte_second) begin
                    n_sum   = sum_add;
                    n_phase = PH_LENGTH;
                    n_cnt   = '0;
                end else begin
                    err = 1'b1;
                end
            end
            PH_LENGTH: begin
                n_sum = sum_add;
                if (r_cnt == 9'd0) begin
                    n_len = {8'd0, i_rx_byte};
                    n_cnt = 9'd1;
                end else begin
                    n_len = len_full;
                    n_cnt = '0;
                    if ({16'd0, len_full} > 32'(MAX_PAYLOAD)) begin
                        err = 1'b1;
                    end else begin
                        n_phase = PH_MSGID;
                    end
                end
            end
            PH_MSGID: begin
                n_sum = sum_add;
                if (r_cnt == 9'd0) begin
                    n_msg = {8'd0, i_rx_byte};
                    n_cnt = 9'd1;
                end else begin
                    n_msg   = {i_rx_byte, r_msg[7:0]};
                    n_cnt   = '0;
                    n_phase = PH_SRC;
                end
            end
            PH_SRC: begin
                if (i_rx_byte == i_cfg.source_device_id) begin
                    n_sum   = sum_add;
                    n_phase = PH_DST;
                end else begin
                    err = 1'b1;
                end
            end
            PH_DST: begin
                if (i_rx_byte == i_cfg.dest_device_id) begin
                    n_sum   = sum_add;
                    n_cnt   = '0;
                    n_phase = (r_len == 16'd0) ? PH_CHECK : PH_DATA;
                end else begin
                    err = 1'b1;
                end
            end
            PH_DATA: begin
                n_sum  = sum_add;
                pvalid = 1'b1;
                if (cnt_inc == r_len[8:0]) begin
                    n_cnt   = '0;
                    n_phase = PH_CHECK;
                end else begin
                    n_cnt = cnt_inc;
                end
            end
            PH_CHECK: begin
                if (r_cnt == 9'd0) begin
                    n_ck_low = i_rx_byte;
                    n_cnt    = 9'd1;
                end else begin
                    n_cnt = '0;
                    if ({i_rx_byte, r_ck_low} == r_sum) begin
                        n_phase = PH_WAIT;
                        o_result.parse_status = ST_COMPLETE;
                    end else begin
                        err = 1'b1;
                    end
                end
            end
            PH_WAIT: begin
                if (i_rx_byte == i_cfg.start_byte_first) begin
                    n_phase = PH_START1;
                    n_cnt   = '0;
                    n_sum   = {8'd0, i_rx_byte};
                end else begin
                    err = 1'b1;
                end
            end
        endcase

        // Drop the whole frame on any mismatch or on an oversized length
        if (err) begin
            n_phase  = PH_WAIT;
            n_cnt    = '0;
            n_len    = '0;
            n_msg    = '0;
            n_sum    = '0;
            n_ck_low = '0;
            o_result.parse_status = ST_ERROR;
        end

        o_result.payload_valid = pvalid;
        o_result.payload_byte  = pvalid ? i_rx_byte : 8'd0;
        o_result.payload_index = pvalid ? r_cnt[7:0] : 8'd0;
        o_result.frame_msg_id  = n_msg;
        o_result.frame_length  = n_len[8:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_WAIT;
            r_cnt    <= '0;
            r_len    <= '0;
            r_msg    <= '0;
            r_sum    <= '0;
            r_ck_low <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_len    <= n_len;
            r_msg    <= n_msg;
            r_sum    <= n_sum;
            r_ck_low <= n_ck_low;
        end
    end

endmodule

@@ src/sonar_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// sonar_frame_receiver
// Byte-serial receiver for ping-protocol frames: checks header bytes,
// forwards payload bytes with their index and verifies the 16-bit checksum.
// ----------------------------------------------------------------------------
//
//  channel   direction  signals                          one request is
//  -------   ---------  -------------------------------  -------------------
//  s (in)    slave      i_s_tvalid/o_s_tready/i_s_tdata  one received byte
//  m (out)   master     o_m_tvalid/i_m_tready/o_m_tdata  one parse result
//                       o_m_tuser
//  cfg       slave      i_cfg_valid/o_cfg_ready          one register write
//                       i_cfg_index/i_cfg_data
//
//  Flow: one byte per clock sustained while the sink is ready; a byte is
//  held in the input register, its parse step runs between that register
//  and the result register, which holds the result for the m channel.
//  Reset: synchronous, active low; clears frame state and valid flags and
//  loads the start-byte and device-id register defaults.
//  Stalls: while the result register is held by i_m_tready low, the input
//  register still takes one byte; further bytes wait on o_s_tready.
//  The config port always accepts; write it only while the block is idle.
// ----------------------------------------------------------------------------
module sonar_frame_receiver
    import sfr_pkg::*;
#(
    parameter int MAX_PAYLOAD = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input bytes
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [7:0]           i_s_tdata,   // [7:0] rx_byte
    // parse results
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // [7:0] payload_byte, [15:8] payload_index, [31:16] frame_msg_id,
    // [40:32] frame_length, [47:41] zero
    output logic [M_TDATA_W-1:0] o_m_tdata,
    // [1:0] parse_status, [2] payload_valid
    output logic [M_TUSER_W-1:0] o_m_tuser,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [7:0]           i_cfg_data
);

    t_cfg    r_cfg;
    logic    r_in_valid;
    logic [7:0] r_in_byte;
    logic    r_out_valid;
    t_result r_out;
    t_result step_result;
    logic    advance;

    // The parse step moves a byte into the result register when that
    // register is empty or being emptied this cycle.
    assign advance     = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte_first  <= START_FIRST_RST;
            r_cfg.start_byte_second <= START_SECOND_RST;
            r_cfg.source_device_id  <= '0;
            r_cfg.dest_device_id    <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_START_FIRST:  r_cfg.start_byte_first  <= i_cfg_data;
                CFG_START_SECOND: r_cfg.start_byte_second <= i_cfg_data;
                CFG_SOURCE_ID:    r_cfg.source_device_id  <= i_cfg_data;
                CFG_DEST_ID:      r_cfg.dest_device_id    <= i_cfg_data;
            endcase
        end
    end

    // Input register: hold the byte until the parse step takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_byte <= i_s_tdata;
        end
    end

    sfr_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (advance),
        .i_rx_byte (r_in_byte),
        .i_cfg     (r_cfg),
        .o_result  (step_result)
    );

    // Result register: hold while the sink stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_out.frame_length, r_out.frame_msg_id,
                         r_out.payload_index, r_out.payload_byte};
    assign o_m_tuser  = {r_out.payload_valid, r_out.parse_status};

endmodule
